[src/acst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acst_pkg: shared types and constants of the CSI stream tokenizer
// Character codes, register map, result item layout and queue push bundle.
// ----------------------------------------------------------------------------
package acst_pkg;

   localparam int VALUE_BITS_DEFAULT = 16;
   localparam int PARAM_W            = 16;
   localparam int QUEUE_DEPTH        = 4;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_IDX_W          = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_UTF8_GROUPING = '0;

   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_LBR  = 8'h5B;
   localparam logic [7:0] CH_M    = 8'h6D;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_D0   = 8'h30;
   localparam logic [7:0] CH_D9   = 8'h39;

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'b001,
      MODE_HELD  = 3'b010,
      MODE_SEQ   = 3'b100
   } mode_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               in_sequence;
      logic               token_start;
      logic               sequence_final;
      logic               param_valid;
      logic [PARAM_W-1:0] param_value;
      logic               param_empty;
      logic               stream_done;
      logic               run_last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   function automatic rsp_item_type make_item(
      input logic [7:0]         b,
      input logic               inseq,
      input logic               start,
      input logic               fin,
      input logic               pvalid,
      input logic [PARAM_W-1:0] pval,
      input logic               pempty
   );
      rsp_item_type r;
      r.out_byte       = b;
      r.in_sequence    = inseq;
      r.token_start    = start;
      r.sequence_final = fin;
      r.param_valid    = pvalid;
      r.param_value    = pvalid ? pval : '0;
      r.param_empty    = pvalid & pempty;
      r.stream_done    = 1'b0;
      r.run_last       = 1'b0;
      return r;
   endfunction

endpackage

[src/acst_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acst_req_if: input byte channel
// Valid/ready channel carrying one text byte and its end-of-string mark.
// ----------------------------------------------------------------------------
interface acst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       string_end;

   modport source (output valid, output data_byte, output string_end, input ready);
   modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

[src/acst_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acst_rsp_if: result channel
// Valid/ready channel carrying one classified byte with its token flags.
// ----------------------------------------------------------------------------
interface acst_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        in_sequence;
   logic        token_start;
   logic        sequence_final;
   logic        param_valid;
   logic [15:0] param_value;
   logic        param_empty;
   logic        stream_done;
   logic        run_last;

   modport source (
      output valid, output out_byte, output in_sequence, output token_start,
      output sequence_final, output param_valid, output param_value,
      output param_empty, output stream_done, output run_last, input ready
   );
   modport sink (
      input valid, input out_byte, input in_sequence, input token_start,
      input sequence_final, input param_valid, input param_value,
      input param_empty, input stream_done, input run_last, output ready
   );
endinterface

[src/acst_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acst_csr: configuration register port
// APB-style access to the UTF-8 grouping control bit.
// ----------------------------------------------------------------------------
module acst_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [acst_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [acst_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [acst_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output logic                            utf8_grouping
);

   logic                           grouping_ff;
   logic                           grouping_in;
   logic                           wr_en;
   logic [acst_pkg::CSR_IDX_W-1:0] reg_idx;

   assign reg_idx    = csr_paddr[acst_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      grouping_in = grouping_ff;
      if (wr_en && reg_idx == acst_pkg::REG_UTF8_GROUPING) begin
         grouping_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grouping_ff <= 1'b1;
      end else begin
         grouping_ff <= grouping_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == acst_pkg::REG_UTF8_GROUPING) begin
         csr_prdata[0] = grouping_ff;
      end
   end

   assign utf8_grouping = grouping_ff;

endmodule

[src/acst_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acst_parse: byte classifier and CSI parameter decoder
// Holds parse state and turns each accepted byte into zero to two results.
// ----------------------------------------------------------------------------
module acst_parse #(
   parameter int VALUE_BITS = acst_pkg::VALUE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               string_end,
   input  logic               utf8_grouping,
   output acst_pkg::push_type push
);

   localparam int PW = acst_pkg::PARAM_W;
   localparam int VB = VALUE_BITS;

   typedef struct packed {
      logic       start;
      logic [1:0] cont;
   } plain_type;

   function automatic plain_type plain_class(
      input logic [7:0] b,
      input logic [1:0] cont,
      input logic       grp
   );
      plain_type r;
      r.start = 1'b1;
      r.cont  = 2'd0;
      if (grp && cont != 2'd0 && b[7:6] == 2'b10) begin
         r.start = 1'b0;
         r.cont  = cont - 2'd1;
      end else if (grp && b[7:5] == 3'b110) begin
         r.cont = 2'd1;
      end else if (grp && b[7:4] == 4'b1110) begin
         r.cont = 2'd2;
      end else if (grp && b[7:3] == 5'b11110) begin
         r.cont = 2'd3;
      end
      return r;
   endfunction

   acst_pkg::mode_type mode_ff, mode_in;
   logic [1:0]         cont_ff, cont_in;
   logic [VB-1:0]      acc_ff, acc_in;
   logic               digit_ff, digit_in;
   logic               bracket_ff, bracket_in;

   acst_pkg::rsp_item_type r0, r1;
   logic [1:0]             n;
   plain_type              pl;
   logic [1:0]             cont_sel;
   logic [VB+3:0]          acc_ext;
   logic [VB+3:0]          acc_sum;
   logic [VB-1:0]          acc_sat;
   logic [PW+VB-1:0]       acc_wide;
   logic [PW-1:0]          acc_low;
   logic                   is_digit;

   assign cont_sel = (mode_ff == acst_pkg::MODE_HELD) ? 2'd0 : cont_ff;
   assign pl       = plain_class(data_byte, cont_sel, utf8_grouping);
   assign is_digit = (data_byte >= acst_pkg::CH_D0) && (data_byte <= acst_pkg::CH_D9);
   assign acc_ext  = {4'b0000, acc_ff};
   assign acc_sum  = (acc_ext << 3) + (acc_ext << 1)
                   + {{VB{1'b0}}, data_byte[3:0] - acst_pkg::CH_D0[3:0]};
   assign acc_sat  = (acc_sum[VB+3:VB] != 4'd0) ? {VB{1'b1}} : acc_sum[VB-1:0];
   assign acc_wide = {{PW{1'b0}}, acc_ff};
   assign acc_low  = acc_wide[PW-1:0];

   always_comb begin
      mode_in    = mode_ff;
      cont_in    = cont_ff;
      acc_in     = acc_ff;
      digit_in   = digit_ff;
      bracket_in = bracket_ff;
      r0         = '0;
      r1         = '0;
      n          = 2'd0;
      case (mode_ff)
         acst_pkg::MODE_HELD: begin
            if (data_byte == acst_pkg::CH_LBR) begin
               r0 = acst_pkg::make_item(acst_pkg::CH_ESC, 1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b0);
               r1 = acst_pkg::make_item(data_byte, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0);
               n          = 2'd2;
               mode_in    = acst_pkg::MODE_SEQ;
               cont_in    = 2'd0;
               acc_in     = '0;
               digit_in   = 1'b0;
               bracket_in = 1'b1;
            end else begin
               r0 = acst_pkg::make_item(acst_pkg::CH_ESC, 1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b0);
               n       = 2'd1;
               mode_in = acst_pkg::MODE_PLAIN;
               cont_in = 2'd0;
               if (data_byte == acst_pkg::CH_ESC) begin
                  if (string_end) begin
                     r1 = acst_pkg::make_item(data_byte, 1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b0);
                     n  = 2'd2;
                  end else begin
                     mode_in = acst_pkg::MODE_HELD;
                  end
               end else begin
                  r1 = acst_pkg::make_item(data_byte, 1'b0, pl.start, 1'b0, 1'b0, '0, 1'b0);
                  n       = 2'd2;
                  cont_in = pl.cont;
               end
            end
         end
         acst_pkg::MODE_SEQ: begin
            n = 2'd1;
            if (is_digit) begin
               r0 = acst_pkg::make_item(data_byte, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0);
               acc_in     = acc_sat;
               digit_in   = 1'b1;
               bracket_in = 1'b0;
            end else if (data_byte == acst_pkg::CH_SEMI) begin
               r0 = acst_pkg::make_item(data_byte, 1'b1, 1'b0, 1'b0, 1'b1, acc_low, ~digit_ff);
               acc_in     = '0;
               digit_in   = 1'b0;
               bracket_in = 1'b0;
            end else begin
               if (data_byte == acst_pkg::CH_M) begin
                  if (bracket_ff) begin
                     r0 = acst_pkg::make_item(data_byte, 1'b1, 1'b0, 1'b1, 1'b1, '0, 1'b0);
                  end else begin
                     r0 = acst_pkg::make_item(data_byte, 1'b1, 1'b0, 1'b1, 1'b1, acc_low,
                                              ~digit_ff);
                  end
               end else begin
                  r0 = acst_pkg::make_item(data_byte, 1'b1, 1'b0, 1'b1, 1'b0, '0, 1'b0);
               end
               mode_in    = acst_pkg::MODE_PLAIN;
               cont_in    = 2'd0;
               acc_in     = '0;
               digit_in   = 1'b0;
               bracket_in = 1'b0;
            end
         end
         default: begin
            mode_in = acst_pkg::MODE_PLAIN;
            if (data_byte == acst_pkg::CH_ESC) begin
               cont_in = 2'd0;
               if (string_end) begin
                  r0 = acst_pkg::make_item(data_byte, 1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b0);
                  n  = 2'd1;
               end else begin
                  mode_in = acst_pkg::MODE_HELD;
               end
            end else begin
               r0 = acst_pkg::make_item(data_byte, 1'b0, pl.start, 1'b0, 1'b0, '0, 1'b0);
               n       = 2'd1;
               cont_in = pl.cont;
            end
         end
      endcase
      if (string_end) begin
         mode_in    = acst_pkg::MODE_PLAIN;
         cont_in    = 2'd0;
         acc_in     = '0;
         digit_in   = 1'b0;
         bracket_in = 1'b0;
      end
      if (n == 2'd2) begin
         r1.run_last    = 1'b1;
         r1.stream_done = string_end;
      end else if (n == 2'd1) begin
         r0.run_last    = 1'b1;
         r0.stream_done = string_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= acst_pkg::MODE_PLAIN;
         cont_ff    <= 2'd0;
         acc_ff     <= '0;
         digit_ff   <= 1'b0;
         bracket_ff <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         cont_ff    <= cont_in;
         acc_ff     <= acc_in;
         digit_ff   <= digit_in;
         bracket_ff <= bracket_in;
      end
   end

   assign push.count  = accept ? n : 2'd0;
   assign push.first  = r0;
   assign push.second = r1;

endmodule

[src/acst_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acst_outq: result queue
// Small register queue taking up to two items per cycle and giving one.
// ----------------------------------------------------------------------------
module acst_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  acst_pkg::push_type     push,
   input  logic                   pop,
   output acst_pkg::rsp_item_type head,
   output logic                   not_empty,
   output logic                   room
);

   localparam int DEPTH = acst_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   acst_pkg::rsp_item_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign do_pop    = pop & not_empty;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   assign head      = mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));

endmodule

[src/ansi_csi_stream_tokenizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_csi_stream_tokenizer_top: CSI escape sequence stream tokenizer
// Output: each result is queued as its byte is accepted and offered from the
//   queue head; a held ESC is released with the results of the following byte.
// Throughput: one byte per cycle while the queue has room for two results; the
//   four-entry queue feeds the single result port one result at a time.
// Reset: synchronous; clears parse state and the queue, grouping returns to 1.
// ----------------------------------------------------------------------------
module ansi_csi_stream_tokenizer_top #(
   parameter int VALUE_BITS = acst_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   acst_req_if.sink                        req_chan,
   acst_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [acst_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [acst_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [acst_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic                   utf8_grouping;
   logic                   accept;
   logic                   room;
   logic                   not_empty;
   acst_pkg::push_type     push;
   acst_pkg::rsp_item_type head;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid & room;

   acst_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .utf8_grouping (utf8_grouping)
   );

   acst_parse #(
      .VALUE_BITS (VALUE_BITS)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_chan.data_byte),
      .string_end    (req_chan.string_end),
      .utf8_grouping (utf8_grouping),
      .push          (push)
   );

   acst_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_chan.ready),
      .head      (head),
      .not_empty (not_empty),
      .room      (room)
   );

   assign rsp_chan.valid          = not_empty;
   assign rsp_chan.out_byte       = head.out_byte;
   assign rsp_chan.in_sequence    = head.in_sequence;
   assign rsp_chan.token_start    = head.token_start;
   assign rsp_chan.sequence_final = head.sequence_final;
   assign rsp_chan.param_valid    = head.param_valid;
   assign rsp_chan.param_value    = head.param_value;
   assign rsp_chan.param_empty    = head.param_empty;
   assign rsp_chan.stream_done    = head.stream_done;
   assign rsp_chan.run_last       = head.run_last;

endmodule

[src/acst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acst_checker: port-level checks of the tokenizer
// Watches the result channel for emptiness after reset, flag consistency and handshake hold.
// ----------------------------------------------------------------------------
module acst_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_in_sequence,
   input logic rsp_token_start,
   input logic rsp_sequence_final,
   input logic rsp_param_valid,
   input logic rsp_param_empty,
   input logic rsp_stream_done,
   input logic rsp_run_last
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_valid_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_done_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_run_last)
      else $error("end of string not on last result of its byte");

   a_param_flags : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_param_valid || rsp_param_empty)
      |-> rsp_param_valid && rsp_in_sequence && !rsp_token_start)
      else $error("parameter reported outside a sequence");

   a_final_seq : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sequence_final
      |-> rsp_in_sequence && !rsp_token_start)
      else $error("final byte flagged outside a sequence");

endmodule

bind ansi_csi_stream_tokenizer_top acst_checker u_acst_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_in_sequence    (rsp_chan.in_sequence),
   .rsp_token_start    (rsp_chan.token_start),
   .rsp_sequence_final (rsp_chan.sequence_final),
   .rsp_param_valid    (rsp_chan.param_valid),
   .rsp_param_empty    (rsp_chan.param_empty),
   .rsp_stream_done    (rsp_chan.stream_done),
   .rsp_run_last       (rsp_chan.run_last)
);

[dv/ansi_csi_stream_tokenizer_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_csi_stream_tokenizer_top_test: testbench of the CSI stream tokenizer
// Feeds text strings, with control sequences, UTF-8 characters, broken
// fragments and noise, through the byte channel with random idle cycles on
// both sides. A token predictor runs alongside and each result item is
// compared field by field with the oldest predicted token. The grouping
// register is written between phases over the APB-style port and read back.
// ----------------------------------------------------------------------------
module ansi_csi_stream_tokenizer_top_test;

   localparam int          VALUE_BITS      = 16;
   localparam logic [63:0] VALUE_LIMIT     = (64'd1 << VALUE_BITS) - 64'd1;
   localparam int          MAX_IDLE        = 17;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          WATCHDOG_LIMIT  = 2000;
   localparam int          RANDOM_TARGET   = 1380;
   localparam int          PHASE_ITEMS     = 200;

   localparam logic [acst_pkg::CSR_IDX_W-1:0] REG_UNMAPPED =
      acst_pkg::REG_UTF8_GROUPING + 1'b1;

   logic clock = 1'b0;
   logic reset;

   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [acst_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [acst_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [acst_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   acst_req_if req_chan ();
   acst_rsp_if rsp_chan ();

   ansi_csi_stream_tokenizer_top #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic                   grouping_bit;
   acst_pkg::mode_type     parse_mode;
   logic [1:0]             cont_left;
   logic [31:0]            param_acc;
   logic                   param_seen;
   logic                   after_lbr;

   acst_pkg::rsp_item_type expected_tokens[$];
   logic [7:0]             text_buf[$];

   int   error_count      = 0;
   int   bytes_sent       = 0;
   logic send_idle_on     = 1'b1;
   logic take_idle_on     = 1'b1;
   logic hold_off_request = 1'b0;

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %h want %h", name, got, want));
      end
   endtask

   function automatic acst_pkg::rsp_item_type make_token(
      input logic [7:0] b, input logic inseq, input logic start, input logic fin,
      input logic pvalid, input logic [15:0] pval, input logic pempty
   );
      acst_pkg::rsp_item_type t;
      t.out_byte       = b;
      t.in_sequence    = inseq;
      t.token_start    = start;
      t.sequence_final = fin;
      t.param_valid    = pvalid;
      t.param_value    = pval;
      t.param_empty    = pempty;
      t.stream_done    = 1'b0;
      t.run_last       = 1'b0;
      return t;
   endfunction

   function automatic void reset_parse();
      parse_mode = acst_pkg::MODE_PLAIN;
      cont_left  = '0;
      param_acc  = '0;
      param_seen = 1'b0;
      after_lbr  = 1'b0;
   endfunction

   function automatic logic classify_plain(input logic [7:0] b, input logic end_mark,
                                           output acst_pkg::rsp_item_type tok);
      logic start;
      start = 1'b1;
      tok   = '0;
      if (b == acst_pkg::CH_ESC) begin
         cont_left = '0;
         if (end_mark) begin
            tok = make_token(b, 1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b0);
            return 1'b1;
         end
         parse_mode = acst_pkg::MODE_HELD;
         return 1'b0;
      end
      if (grouping_bit && cont_left != 0 && b[7:6] == 2'b10) begin
         start     = 1'b0;
         cont_left = cont_left - 2'd1;
      end else if (grouping_bit && b[7:5] == 3'b110) begin
         cont_left = 2'd1;
      end else if (grouping_bit && b[7:4] == 4'b1110) begin
         cont_left = 2'd2;
      end else if (grouping_bit && b[7:3] == 5'b11110) begin
         cont_left = 2'd3;
      end else begin
         cont_left = '0;
      end
      tok = make_token(b, 1'b0, start, 1'b0, 1'b0, '0, 1'b0);
      return 1'b1;
   endfunction

   function automatic void predict_tokens(input logic [7:0] b, input logic end_mark);
      acst_pkg::rsp_item_type pend[2];
      acst_pkg::rsp_item_type tok;
      logic [63:0]            acc_next;
      int                     n;
      n = 0;
      if (parse_mode == acst_pkg::MODE_HELD) begin
         if (b == acst_pkg::CH_LBR) begin
            pend[0]    = make_token(acst_pkg::CH_ESC, 1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b0);
            pend[1]    = make_token(b, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0);
            n          = 2;
            parse_mode = acst_pkg::MODE_SEQ;
            cont_left  = '0;
            param_acc  = '0;
            param_seen = 1'b0;
            after_lbr  = 1'b1;
         end else begin
            pend[0]    = make_token(acst_pkg::CH_ESC, 1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b0);
            n          = 1;
            parse_mode = acst_pkg::MODE_PLAIN;
            cont_left  = '0;
            if (classify_plain(b, end_mark, tok)) begin
               pend[n] = tok;
               n++;
            end
         end
      end else if (parse_mode == acst_pkg::MODE_SEQ) begin
         if (b >= acst_pkg::CH_D0 && b <= acst_pkg::CH_D9) begin
            acc_next = 64'(param_acc) * 64'd10 + 64'(b - acst_pkg::CH_D0);
            if (acc_next > VALUE_LIMIT) acc_next = VALUE_LIMIT;
            param_acc  = acc_next[31:0];
            param_seen = 1'b1;
            after_lbr  = 1'b0;
            pend[0]    = make_token(b, 1'b1, 1'b0, 1'b0, 1'b0, '0, 1'b0);
         end else if (b == acst_pkg::CH_SEMI) begin
            pend[0]    = make_token(b, 1'b1, 1'b0, 1'b0, 1'b1, param_acc[15:0],
                                    !param_seen);
            param_acc  = '0;
            param_seen = 1'b0;
            after_lbr  = 1'b0;
         end else if (b == acst_pkg::CH_M) begin
            if (after_lbr) begin
               pend[0] = make_token(b, 1'b1, 1'b0, 1'b1, 1'b1, '0, 1'b0);
            end else begin
               pend[0] = make_token(b, 1'b1, 1'b0, 1'b1, 1'b1, param_acc[15:0],
                                    !param_seen);
            end
            reset_parse();
         end else begin
            pend[0] = make_token(b, 1'b1, 1'b0, 1'b1, 1'b0, '0, 1'b0);
            reset_parse();
         end
         n = 1;
      end else begin
         if (classify_plain(b, end_mark, tok)) begin
            pend[0] = tok;
            n       = 1;
         end
      end
      if (end_mark) reset_parse();
      if (n > 0) begin
         pend[n-1].stream_done = end_mark;
         pend[n-1].run_last    = 1'b1;
      end
      for (int i = 0; i < n; i++) expected_tokens.push_back(pend[i]);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic end_mark);
      int gap;
      gap = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.string_end <= end_mark;
      do @(posedge clock); while (!req_chan.ready);
      predict_tokens(b, end_mark);
      bytes_sent++;
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic compose_text(input int target_len);
      int         nparams;
      int         ndig;
      int         len;
      logic [7:0] b;
      text_buf.delete();
      while (text_buf.size() < target_len) begin
         case ($urandom_range(0, 9))
            0, 1, 2: text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            3, 4: begin
               len = $urandom_range(2, 4);
               case (len)
                  2:       b = 8'hC0 | 8'($urandom_range(0, 31));
                  3:       b = 8'hE0 | 8'($urandom_range(0, 15));
                  default: b = 8'hF0 | 8'($urandom_range(0, 7));
               endcase
               text_buf.push_back(b);
               repeat (len - 1) text_buf.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
            5, 6, 7: begin
               text_buf.push_back(acst_pkg::CH_ESC);
               text_buf.push_back(acst_pkg::CH_LBR);
               nparams = $urandom_range(0, 3);
               for (int p = 0; p < nparams; p++) begin
                  if (p > 0) text_buf.push_back(acst_pkg::CH_SEMI);
                  ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                     : $urandom_range(0, 3);
                  repeat (ndig) begin
                     text_buf.push_back(acst_pkg::CH_D0 + 8'($urandom_range(0, 9)));
                  end
               end
               if ($urandom_range(0, 1) == 1) begin
                  text_buf.push_back(acst_pkg::CH_M);
               end else begin
                  do b = 8'($urandom_range(0, 255));
                  while ((b >= acst_pkg::CH_D0 && b <= acst_pkg::CH_D9) ||
                         b == acst_pkg::CH_SEMI || b == acst_pkg::CH_M);
                  text_buf.push_back(b);
               end
            end
            8: text_buf.push_back(8'($urandom_range(0, 255)));
            default: begin
               case ($urandom_range(0, 2))
                  0: text_buf.push_back(acst_pkg::CH_ESC);
                  1: begin
                     text_buf.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                     text_buf.push_back(8'h80 | 8'($urandom_range(0, 63)));
                  end
                  default: text_buf.push_back(8'h80 | 8'($urandom_range(0, 63)));
               endcase
            end
         endcase
      end
      if (text_buf.size() > 1 && $urandom_range(0, 7) == 0) void'(text_buf.pop_back());
   endtask

   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [acst_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      logic [acst_pkg::CSR_DATA_W-1:0] rd;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == acst_pkg::REG_UTF8_GROUPING) grouping_bit = value[0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {acst_pkg::REG_UTF8_GROUPING, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      check_field("utf8_grouping", 16'(rd[0]), 16'(grouping_bit));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_directed();
      send_idle_on = 1'b1;
      take_idle_on = 1'b1;
      text_buf = '{8'h00, 8'hFF, 8'hC3, 8'hA9, 8'h80};
      send_text();
      text_buf = '{acst_pkg::CH_ESC, acst_pkg::CH_LBR, acst_pkg::CH_M};
      send_text();
      text_buf = '{8'hE2, acst_pkg::CH_ESC, acst_pkg::CH_ESC, 8'h41};
      send_text();
      text_buf = '{acst_pkg::CH_ESC, acst_pkg::CH_LBR, acst_pkg::CH_SEMI,
                   acst_pkg::CH_D9, acst_pkg::CH_D9, acst_pkg::CH_D9,
                   acst_pkg::CH_D9, acst_pkg::CH_D9, 8'h48};
      send_text();
      text_buf = '{acst_pkg::CH_ESC};
      send_text();
      text_buf = '{acst_pkg::CH_ESC, 8'h71};
      send_text();
      text_buf = '{acst_pkg::CH_ESC, acst_pkg::CH_LBR, 8'h35};
      send_text();
      finish_phase();
   endtask

   task automatic test_register_map();
      int phase_start;
      write_csr(REG_UNMAPPED, {31'h7FFF_FFFF, ~grouping_bit});
      write_csr(acst_pkg::REG_UTF8_GROUPING, 32'hFFFF_FFFE);
      phase_start = bytes_sent;
      while (bytes_sent < phase_start + 150) begin
         send_idle_on = ($urandom_range(0, 3) != 0);
         take_idle_on = ($urandom_range(0, 3) != 0);
         compose_text($urandom_range(1, 40));
         send_text();
      end
      finish_phase();
      write_csr(acst_pkg::REG_UTF8_GROUPING, 32'h0000_0001);
   endtask

   task automatic test_random_streams();
      int          phase_start;
      logic [31:0] value;
      phase_start = bytes_sent;
      while (bytes_sent < RANDOM_TARGET) begin
         if (bytes_sent - phase_start >= PHASE_ITEMS) begin
            finish_phase();
            value    = $urandom();
            value[0] = ~grouping_bit;
            write_csr(acst_pkg::REG_UTF8_GROUPING, value);
            phase_start = bytes_sent;
         end
         send_idle_on = ($urandom_range(0, 3) != 0);
         take_idle_on = ($urandom_range(0, 3) != 0);
         compose_text($urandom_range(1, 40));
         send_text();
      end
      finish_phase();
   endtask

   task automatic test_backpressure();
      send_idle_on     = 1'b0;
      take_idle_on     = 1'b0;
      hold_off_request = 1'b1;
      compose_text(70);
      send_text();
      finish_phase();
   endtask

   initial begin : result_taker
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end else begin
            stall = take_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin : result_check
      acst_pkg::rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_tokens.size() == 0) begin
            report_error($sformatf("unexpected item, byte %h", rsp_chan.out_byte));
         end else begin
            want = expected_tokens.pop_front();
            check_field("out_byte", 16'(rsp_chan.out_byte), 16'(want.out_byte));
            check_field("in_sequence", 16'(rsp_chan.in_sequence), 16'(want.in_sequence));
            check_field("token_start", 16'(rsp_chan.token_start), 16'(want.token_start));
            check_field("sequence_final", 16'(rsp_chan.sequence_final),
                        16'(want.sequence_final));
            check_field("param_valid", 16'(rsp_chan.param_valid), 16'(want.param_valid));
            check_field("param_value", rsp_chan.param_value, want.param_value);
            check_field("param_empty", 16'(rsp_chan.param_empty), 16'(want.param_empty));
            check_field("stream_done", 16'(rsp_chan.stream_done), 16'(want.stream_done));
            check_field("run_last", 16'(rsp_chan.run_last), 16'(want.run_last));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ansi_csi_stream_tokenizer_top test failed");
         $finish;
      end
   end

   initial begin : run_tests
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= '0;
      req_chan.string_end <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      grouping_bit = 1'b1;
      reset_parse();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_map();
      test_random_streams();
      test_backpressure();
      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("ansi_csi_stream_tokenizer_top test passed");
      end else begin
         $display("ansi_csi_stream_tokenizer_top test failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/acst_pkg.sv
src/acst_req_if.sv
src/acst_rsp_if.sv
src/acst_csr.sv
src/acst_parse.sv
src/acst_outq.sv
src/ansi_csi_stream_tokenizer_top.sv
src/acst_checker.sv
dv/ansi_csi_stream_tokenizer_top_test.sv
